>>> rtl/asm16_pkg.sv
// shared types, constants and the approximate 4:2 compressor for the 16x16 multiplier
package asm16_pkg;

  localparam int OpW     = 16;
  localparam int ProdW   = 32;
  localparam int NumPp   = 16;
  localparam int NumRed  = 8;

  typedef logic signed [OpW-1:0]   operand_t;
  typedef logic signed [ProdW-1:0] product_t;
  typedef logic [ProdW-1:0]        row_t;

  // approximate 4:2 compressor, returns {carry, sum}
  function automatic logic [1:0] cmp42(input logic a, input logic b,
                                       input logic c, input logic d);
    logic ab;
    logic cd;
    ab = a ^ b;
    cd = c ^ d;
    return {(c & d) | (ab & cd) | (a & b), ab ^ cd};
  endfunction

endpackage

>>> rtl/asm16_if.sv
// stream channels carrying operand pairs and products
interface asm16_in_if;
  logic                valid;
  logic                ready;
  asm16_pkg::operand_t multiplicand;
  asm16_pkg::operand_t multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface asm16_out_if;
  logic                valid;
  logic                ready;
  asm16_pkg::product_t product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

>>> rtl/approx_signed_mult16.sv
// approximate signed 16x16 multiplier, four-stage pipeline
//
// Gives an approximate 32-bit signed product of two 16-bit signed operands
// (Baugh-Wooley partial products, fixed approximate 4:2 compressor tree down
// to eight rows, then an exact adder tree, wrapped to 32 bits). One operand
// pair is taken every cycle unless the output stalls; products pass through
// red_q, sum4_q, sum2_q and prod_q. Stage 1 forms and compresses the partial
// products, stages 2 to 4 are the three levels of 32-bit adders. When the
// output is stalled every stage holds, so nothing is lost or repeated.
module approx_signed_mult16 (
  input  logic             clk_i,
  input  logic             rst_ni,
  asm16_in_if.sink         in_i,
  asm16_out_if.source      out_o
);

  asm16_pkg::row_t [asm16_pkg::NumPp-1:0]  rows1;
  asm16_pkg::row_t [asm16_pkg::NumRed-1:0] rows2;
  asm16_pkg::row_t [asm16_pkg::NumRed-1:0] red_q;
  asm16_pkg::row_t [3:0]                   sum4_q;
  asm16_pkg::row_t [1:0]                   sum2_q;
  asm16_pkg::row_t                         prod_q;
  asm16_pkg::row_t                         aext;
  logic [3:0]                              vld_q;
  logic                                    en;

  assign en          = !vld_q[3] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[3];
  assign out_o.product = asm16_pkg::product_t'(prod_q);

  // partial product rows
  assign aext = {{(asm16_pkg::ProdW - asm16_pkg::OpW){in_i.multiplicand[asm16_pkg::OpW-1]}},
                 in_i.multiplicand};

  always_comb begin
    for (int n = 0; n < asm16_pkg::NumPp; n++) begin
      rows1[n] = in_i.multiplier[n] ? (aext << n) : '0;
      rows1[n][n+15] = ~rows1[n][n+15];
    end
    rows1[15] = rows1[15] ^ 32'h7FFF_8000;
    rows1[0][16] = 1'b1;
    rows1[15][31] = 1'b1;
  end

  // fixed compressor wiring; later wires overwrite earlier compressor outputs
  always_comb begin
    logic [1:0] cs;
    rows2 = '0;
    cs = '0;
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 4; y++) begin
        rows2[x][y] = rows1[x][y];
      end
    end
    rows2[0][4] = rows1[0][4] ^ rows1[1][4];
    rows2[1][4] = rows1[2][4];
    rows2[2][4] = rows1[3][4];
    rows2[3][4] = rows1[4][4];

    for (int y = 5; y < 17; y++) begin
      cs = asm16_pkg::cmp42(rows1[0][y], rows1[1][y], rows1[2][y], rows1[3][y]);
      rows2[0][y] = cs[0];
      rows2[1][y+1] = cs[1];
    end
    for (int y = 7; y < 17; y++) begin
      cs = asm16_pkg::cmp42(rows1[4][y], rows1[5][y], rows1[6][y], rows1[7][y]);
      rows2[2][y] = cs[0];
      rows2[3][y+1] = cs[1];
    end
    for (int y = 11; y < 17; y++) begin
      cs = asm16_pkg::cmp42(rows1[8][y], rows1[9][y], rows1[10][y], rows1[11][y]);
      rows2[4][y] = cs[0];
      rows2[5][y+1] = cs[1];
    end
    for (int y = 15; y < 17; y++) begin
      cs = asm16_pkg::cmp42(rows1[12][y], rows1[13][y], rows1[14][y], rows1[15][y]);
      rows2[6][y] = cs[0];
      rows2[7][y+1] = cs[1];
    end
    // upper columns slide the row window with the column
    for (int y = 17; y < 27; y++) begin
      cs = asm16_pkg::cmp42(rows1[y-15][y], rows1[y-14][y], rows1[y-13][y], rows1[y-12][y]);
      rows2[0][y] = cs[0];
      rows2[1][y+1] = cs[1];
    end
    for (int y = 17; y < 24; y++) begin
      cs = asm16_pkg::cmp42(rows1[y-11][y], rows1[y-10][y], rows1[y-9][y], rows1[y-8][y]);
      rows2[2][y] = cs[0];
      rows2[3][y+1] = cs[1];
    end
    for (int y = 17; y < 20; y++) begin
      cs = asm16_pkg::cmp42(rows1[y-7][y], rows1[y-6][y], rows1[y-5][y], rows1[y-4][y]);
      rows2[4][y] = cs[0];
      rows2[5][y+1] = cs[1];
    end

    rows2[1][5]  = rows1[0][4] & rows1[1][4];
    rows2[2][5]  = rows1[4][5];
    rows2[3][5]  = rows1[5][5];
    rows2[2][6]  = rows1[4][6] ^ rows1[5][6];
    rows2[3][6]  = rows1[6][6];
    rows2[3][7]  = rows1[4][6] & rows1[5][6];
    rows2[4][8]  = rows1[8][8];
    rows2[4][9]  = rows1[8][9];
    rows2[5][9]  = rows1[9][9];
    rows2[4][10] = rows1[8][10];
    rows2[5][10] = rows1[9][10];
    rows2[6][10] = rows1[10][10];
    rows2[6][12] = rows1[12][12];
    rows2[6][13] = rows1[12][13];
    rows2[7][13] = rows1[13][13];
    rows2[6][14] = rows1[12][14] ^ rows1[13][14];
    rows2[7][14] = rows1[14][14];
    rows2[7][15] = rows1[12][14] & rows1[13][14];
    rows2[6][17] = rows1[14][17] ^ rows1[15][17];
    rows2[6][18] = rows1[15][18];
    rows2[7][18] = rows1[14][17] & rows1[15][17];
    rows2[4][20] = rows1[13][20];
    rows2[6][20] = rows1[14][20];
    rows2[7][20] = rows1[15][20];
    rows2[4][21] = rows1[14][21];
    rows2[5][21] = rows1[15][21];
    rows2[4][22] = rows1[15][22];
    rows2[2][24] = rows1[13][24];
    rows2[4][24] = rows1[14][24];
    rows2[5][24] = rows1[15][24];
    rows2[0][25] = rows1[10][25];
    rows2[2][25] = rows1[11][25];
    rows2[3][25] = rows1[12][25];
    rows2[4][25] = rows1[13][25];
    rows2[5][25] = rows1[14][25];
    rows2[6][25] = rows1[15][25];
    rows2[0][26] = rows1[11][26];
    rows2[1][26] = rows1[12][26];
    rows2[2][26] = rows1[13][26];
    rows2[3][26] = rows1[14][26];
    rows2[4][26] = rows1[15][26];
    rows2[0][27] = rows1[12][27];
    rows2[1][27] = rows1[13][27];
    rows2[2][27] = rows1[14][27];
    rows2[3][27] = rows1[15][27];
    rows2[0][28] = rows1[13][28];
    rows2[1][28] = rows1[14][28];
    rows2[2][28] = rows1[15][28];
    rows2[0][29] = rows1[14][29];
    rows2[1][29] = rows1[15][29];
    rows2[0][30] = rows1[15][30];
    rows2[0][31] = rows1[15][31];
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_i.valid};
    end
  end

  // adder tree, sums wrap to 32 bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q <= rows2;
      for (int i = 0; i < 4; i++) begin
        sum4_q[i] <= red_q[2*i] + red_q[2*i+1];
      end
      sum2_q[0] <= sum4_q[0] + sum4_q[1];
      sum2_q[1] <= sum4_q[2] + sum4_q[3];
      prod_q    <= sum2_q[0] + sum2_q[1];
    end
  end

endmodule

>>> test/asm16_product_checker.sv
`timescale 1ns / 1ps
// checker that predicts each approximate product and compares it with the block output
module asm16_product_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  asm16_in_if   in_i,
  asm16_out_if  out_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct {
    asm16_pkg::operand_t mcand;
    asm16_pkg::operand_t mplier;
    asm16_pkg::product_t product;
  } product_rec_t;

  product_rec_t expected_products[$];
  product_rec_t head;
  product_rec_t rec;
  int           printed = 0;
  int           fail_cnt = 0;
  int           pend_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pend_cnt;

  task automatic report_mismatch(input string msg);
    if (printed < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    printed++;
    fail_cnt++;
  endtask

  function automatic logic [1:0] squeeze4(input logic a, input logic b,
                                          input logic c, input logic d);
    logic cy;
    cy = (a & b) | (c & d) | ((a ^ b) & (c ^ d));
    return {cy, a ^ b ^ c ^ d};
  endfunction

  function automatic asm16_pkg::product_t approx_product(input asm16_pkg::operand_t mcand,
                                                         input asm16_pkg::operand_t mplier);
    asm16_pkg::row_t pp [asm16_pkg::NumPp];
    asm16_pkg::row_t rr [asm16_pkg::NumRed];
    asm16_pkg::row_t ext;
    asm16_pkg::row_t acc;
    logic [1:0]      cs;
    int              r0;
    // compressor groups: target row, first and last+1 column, source row offset
    int              grp_row [7] = '{0, 2, 4, 6, 0, 2, 4};
    int              grp_lo  [7] = '{5, 7, 11, 15, 17, 17, 17};
    int              grp_hi  [7] = '{17, 17, 17, 17, 27, 24, 20};
    int              grp_off [7] = '{0, 4, 8, 12, -15, -11, -7};

    ext = {{(asm16_pkg::ProdW-asm16_pkg::OpW){mcand[asm16_pkg::OpW-1]}}, mcand};
    for (int n = 0; n < asm16_pkg::NumPp; n++) begin
      pp[n] = mplier[n] ? (ext << n) : '0;
      pp[n][n+15] = ~pp[n][n+15];
    end
    pp[15] ^= 32'h7FFF_8000;
    pp[0][16] = 1'b1;
    pp[15][31] = 1'b1;

    for (int r = 0; r < asm16_pkg::NumRed; r++) rr[r] = '0;
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 4; y++) rr[x][y] = pp[x][y];

    rr[0][4] = pp[0][4] ^ pp[1][4];
    rr[1][4] = pp[2][4];
    rr[2][4] = pp[3][4];
    rr[3][4] = pp[4][4];

    // later groups slide their source rows with the column
    for (int k = 0; k < 7; k++) begin
      for (int y = grp_lo[k]; y < grp_hi[k]; y++) begin
        r0 = grp_off[k] + ((k >= 4) ? y : 0);
        cs = squeeze4(pp[r0][y], pp[r0+1][y], pp[r0+2][y], pp[r0+3][y]);
        rr[grp_row[k]][y] = cs[0];
        rr[grp_row[k]+1][y+1] = cs[1];
      end
    end

    // plain wires and half adders, some overriding compressor outputs
    rr[1][5]  = pp[0][4] & pp[1][4];
    rr[2][5]  = pp[4][5];
    rr[3][5]  = pp[5][5];
    rr[2][6]  = pp[4][6] ^ pp[5][6];
    rr[3][6]  = pp[6][6];
    rr[3][7]  = pp[4][6] & pp[5][6];
    rr[4][8]  = pp[8][8];
    rr[4][9]  = pp[8][9];
    rr[5][9]  = pp[9][9];
    rr[4][10] = pp[8][10];
    rr[5][10] = pp[9][10];
    rr[6][10] = pp[10][10];
    rr[6][12] = pp[12][12];
    rr[6][13] = pp[12][13];
    rr[7][13] = pp[13][13];
    rr[6][14] = pp[12][14] ^ pp[13][14];
    rr[7][14] = pp[14][14];
    rr[7][15] = pp[12][14] & pp[13][14];
    rr[6][17] = pp[14][17] ^ pp[15][17];
    rr[6][18] = pp[15][18];
    rr[7][18] = pp[14][17] & pp[15][17];
    rr[4][20] = pp[13][20];
    rr[6][20] = pp[14][20];
    rr[7][20] = pp[15][20];
    rr[4][21] = pp[14][21];
    rr[5][21] = pp[15][21];
    rr[4][22] = pp[15][22];
    rr[2][24] = pp[13][24];
    rr[4][24] = pp[14][24];
    rr[5][24] = pp[15][24];
    rr[0][25] = pp[10][25];
    rr[2][25] = pp[11][25];
    rr[3][25] = pp[12][25];
    rr[4][25] = pp[13][25];
    rr[5][25] = pp[14][25];
    rr[6][25] = pp[15][25];
    rr[0][26] = pp[11][26];
    rr[1][26] = pp[12][26];
    rr[2][26] = pp[13][26];
    rr[3][26] = pp[14][26];
    rr[4][26] = pp[15][26];
    rr[0][27] = pp[12][27];
    rr[1][27] = pp[13][27];
    rr[2][27] = pp[14][27];
    rr[3][27] = pp[15][27];
    rr[0][28] = pp[13][28];
    rr[1][28] = pp[14][28];
    rr[2][28] = pp[15][28];
    rr[0][29] = pp[14][29];
    rr[1][29] = pp[15][29];
    rr[0][30] = pp[15][30];
    rr[0][31] = pp[15][31];

    acc = '0;
    for (int r = 0; r < asm16_pkg::NumRed; r++) acc += rr[r];
    return asm16_pkg::product_t'(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_products.delete();
      pend_cnt <= 0;
    end else begin
      // retire before queueing: a product can never leave in its own transfer cycle
      if (out_i.valid && out_i.ready) begin
        if (expected_products.size() == 0) begin
          report_mismatch($sformatf("product %0d with nothing pending", out_i.product));
        end else begin
          head = expected_products.pop_front();
          if (out_i.product !== head.product)
            report_mismatch($sformatf("%0d * %0d: got %0d, want %0d", head.mcand,
                                      head.mplier, out_i.product, head.product));
        end
      end
      if (in_i.valid && in_i.ready) begin
        rec.mcand   = in_i.multiplicand;
        rec.mplier  = in_i.multiplier;
        rec.product = approx_product(in_i.multiplicand, in_i.multiplier);
        expected_products.insert(expected_products.size(), rec);
      end
      pend_cnt <= expected_products.size();
    end
  end

endmodule

>>> test/approx_signed_mult16_tb.sv
`timescale 1ns / 1ps
// top of the multiplier testbench: clock, reset, operand stimulus and verdict
module approx_signed_mult16_tb;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;
  localparam int PhaseItems = 320;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;

  asm16_in_if  in_ch ();
  asm16_out_if out_ch ();

  approx_signed_mult16 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  asm16_product_checker product_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("approx_signed_mult16_tb failed");
      $finish;
    end
  end

  // product sink: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_pair(input asm16_pkg::operand_t mcand, input asm16_pkg::operand_t mplier);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.multiplicand <= mcand;
    in_ch.multiplier   <= mplier;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic asm16_pkg::operand_t pick_operand();
    case ($urandom_range(7))
      0: return ($urandom_range(1)) ? asm16_pkg::operand_t'(16'h8000)
                                    : asm16_pkg::operand_t'(16'h7FFF);
      1: return asm16_pkg::operand_t'($signed($urandom_range(31)) - 16);
      2: return ($urandom_range(1)) ? asm16_pkg::operand_t'(16'hFFFF)
                                    : asm16_pkg::operand_t'(16'h0000);
      default: return asm16_pkg::operand_t'($urandom);
    endcase
  endfunction

  initial begin
    asm16_pkg::operand_t corner_a [18] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                                           16'sh7FFF, 16'shFFFF, 16'sh0001, 16'shFFFF,
                                           16'sh0000, 16'sh8000, 16'sh0001, 16'sh5555,
                                           16'shAAAA, 16'shFFFF, 16'sh7FFF, 16'sh0000,
                                           16'sh00FF, 16'shFF00};
    asm16_pkg::operand_t corner_b [18] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                           16'sh8000, 16'shFFFF, 16'sh0001, 16'sh0001,
                                           16'sh8000, 16'sh0000, 16'shFFFF, 16'shAAAA,
                                           16'sh5555, 16'sh7FFF, 16'shFFFF, 16'sh7FFF,
                                           16'shFF00, 16'sh00FF};
    int idle_set  [4] = '{0, 51, 0, 11};
    int stall_set [4] = '{0, 0, 51, 11};

    in_ch.valid        = 1'b0;
    in_ch.multiplicand = '0;
    in_ch.multiplier   = '0;
    rst_ni             = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_a[i]) send_pair(corner_a[i], corner_b[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int i = 0; i < PhaseItems; i++) send_pair(pick_operand(), pick_operand());
    end

    // sink holds off while operands keep coming, so the pipeline backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = hold_req + 1;
    for (int i = 0; i < 40; i++) send_pair(pick_operand(), pick_operand());

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("approx_signed_mult16_tb passed");
    end else begin
      $display("approx_signed_mult16_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/asm16_pkg.sv
rtl/asm16_if.sv
rtl/approx_signed_mult16.sv
test/asm16_product_checker.sv
test/approx_signed_mult16_tb.sv
